/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/core/fsd_pkg.sv */
// Shared types and constants of the fan-out scan detector.
package fsd_pkg;
    localparam int unsigned IpWidth    = 32;
    localparam int unsigned LimitWidth = 8;
    localparam int unsigned MaxFlagged = 2;

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_SCAN   = 1'b1
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic write_pair;  // store a pair at the write position
        logic load_first;  // outer pointer start: i = 0
        logic next_first;  // i = i + 1
        logic load_inner;  // k = i, j = i, count = 0
        logic next_inner;  // advance j or k
        logic rd_sel;      // 0 reads at k/i, 1 reads at j
        logic cap_s;       // capture reference source from read data
        logic cap_kd;      // capture item k from read data
        logic add_count;   // bump distinct count
        logic flag_src;    // append reference source to flagged list
        logic clr_result;  // clear result registers
    } fsd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic i_done;      // i reached fill level
        logic k_done;      // k reached fill level
        logic j_at_k;      // j reached k
        logic j_at_i;      // j reached i (for seen-before)
        logic src_match;   // read data source equals reference source
        logic pair_match;  // read data equals (reference source, dest of k)
        logic over_limit;  // count exceeds limit
        logic full_flags;  // two sources flagged
    } fsd_stat_t;
endpackage

/* rtl/core/fsd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module fsd_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/core/fsd_datapath.sv */
// Datapath: pair window, scan pointers, distinct counter and flagged list.
`include "assert_macros.svh"
module fsd_datapath #(
    parameter int unsigned WINDOW_DEPTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fsd_pkg::fsd_cmd_t                   cmd,
    output fsd_pkg::fsd_stat_t                  stat,
    input  logic [fsd_pkg::IpWidth-1:0]         in_src,
    input  logic [fsd_pkg::IpWidth-1:0]         in_dest,
    input  logic [fsd_pkg::LimitWidth-1:0]      limit,
    output logic [1:0]                          flagged_count,
    output logic [fsd_pkg::IpWidth-1:0]         first_ip,
    output logic [fsd_pkg::IpWidth-1:0]         second_ip
);
    localparam int unsigned AW = $clog2(WINDOW_DEPTH);
    localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned IW = fsd_pkg::IpWidth;
    localparam int unsigned MW = (CW > fsd_pkg::LimitWidth) ? CW : fsd_pkg::LimitWidth;

    logic [AW-1:0] wpos_reg, opos_reg;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] i_reg, k_reg, j_reg, cnt_reg;
    logic [IW-1:0] s_reg, kd_reg;
    logic [1:0]    nflag_reg;
    logic [IW-1:0] f0_reg, f1_reg;
    logic [AW-1:0] raddr;
    logic [CW-1:0] age;
    logic [CW:0]   slot_sum;
    logic [2*IW-1:0] rdata;

    always_comb begin
        age = cmd.rd_sel ? j_reg : k_reg;
        slot_sum = {{(CW+1-AW){1'b0}}, opos_reg} + {1'b0, age};
        if (slot_sum >= (CW+1)'(WINDOW_DEPTH)) begin
            raddr = AW'(slot_sum - (CW+1)'(WINDOW_DEPTH));
        end else begin
            raddr = AW'(slot_sum);
        end
    end

    fsd_ram #(.WIDTH(2*IW), .DEPTH(WINDOW_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (cmd.write_pair),
        .waddr (wpos_reg),
        .wdata ({in_src, in_dest}),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpos_reg  <= '0;
            opos_reg  <= '0;
            fill_reg  <= '0;
            nflag_reg <= '0;
        end else begin
            if (cmd.write_pair) begin
                wpos_reg <= (wpos_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : wpos_reg + 1'b1;
                if (fill_reg == CW'(WINDOW_DEPTH)) begin
                    opos_reg <= (opos_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : opos_reg + 1'b1;
                end else begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (cmd.clr_result) begin
                nflag_reg <= '0;
            end else if (cmd.flag_src) begin
                nflag_reg <= nflag_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_result) begin
            f0_reg <= '0;
            f1_reg <= '0;
        end else if (cmd.flag_src) begin
            if (nflag_reg == 2'd0) begin
                f0_reg <= s_reg;
            end else begin
                f1_reg <= s_reg;
            end
        end
        if (cmd.load_first) begin
            i_reg <= '0;
        end else if (cmd.next_first) begin
            i_reg <= i_reg + 1'b1;
        end
        // k doubles as the read pointer for i during the seen-before pass
        if (cmd.load_first || cmd.next_first) begin
            k_reg <= cmd.load_first ? '0 : i_reg + 1'b1;
            j_reg <= '0;
        end else if (cmd.load_inner) begin
            k_reg <= i_reg;
            j_reg <= i_reg;
            cnt_reg <= '0;
        end else if (cmd.next_inner) begin
            if (cmd.rd_sel) begin
                j_reg <= j_reg + 1'b1;
            end else begin
                k_reg <= k_reg + 1'b1;
                j_reg <= i_reg;
            end
        end
        if (cmd.add_count) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.cap_s) begin
            s_reg <= rdata[2*IW-1:IW];
        end
        if (cmd.cap_kd) begin
            kd_reg <= rdata[IW-1:0];
        end
    end

    always_comb begin
        stat.i_done     = (i_reg >= fill_reg);
        stat.k_done     = (k_reg >= fill_reg);
        stat.j_at_k     = (j_reg >= k_reg);
        stat.j_at_i     = (j_reg >= i_reg);
        stat.src_match  = (rdata[2*IW-1:IW] == s_reg);
        stat.pair_match = (rdata[2*IW-1:IW] == s_reg) && (rdata[IW-1:0] == kd_reg);
        stat.over_limit = (MW'(cnt_reg) > MW'(limit));
        stat.full_flags = (nflag_reg == 2'd2);
    end

    assign flagged_count = nflag_reg;
    assign first_ip      = f0_reg;
    assign second_ip     = f1_reg;

    `ASSERT_IMPL(a_fill_range, aclk, aresetn, 1'b1, fill_reg <= CW'(WINDOW_DEPTH))
    `ASSERT_IMPL(a_flag_range, aclk, aresetn, 1'b1, nflag_reg <= 2'd2)
    `ASSERT_NEXT(a_wrap_oldest, aclk, aresetn,
        cmd.write_pair && fill_reg == CW'(WINDOW_DEPTH), opos_reg == wpos_reg)
endmodule

/* rtl/core/fsd_ctrl.sv */
// Controller: accepts words, sequences the scan and presents the result.
`include "assert_macros.svh"
module fsd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_op,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output fsd_pkg::fsd_cmd_t  cmd,
    input  fsd_pkg::fsd_stat_t stat
);
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OUTER,   // check i, read item i
        ST_SB_RD,   // read item j for seen-before
        ST_SB_CMP,  // compare
        ST_CNT_K,   // check k, read item k
        ST_CNT_KW,  // capture item k
        ST_CNT_J,   // read item j
        ST_CNT_JW,  // compare item j
        ST_DONE,
        ST_OUT,
        ST_IW       // capture source of item i
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   busy;

    assign busy    = (state_reg != ST_IDLE) && (state_reg != ST_OUT);
    assign s_ready = !busy && !(m_valid_reg && !m_ready);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE, ST_OUT: begin
                state_next = ST_IDLE;
                if (s_valid && s_ready) begin
                    if (fsd_pkg::op_t'(s_op) == fsd_pkg::OP_RECORD) begin
                        cmd.write_pair = 1'b1;
                    end else begin
                        cmd.load_first = 1'b1;
                        cmd.clr_result = 1'b1;
                        state_next     = ST_OUTER;
                    end
                end
            end
            ST_OUTER: begin
                if (stat.i_done || stat.full_flags) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_IW;
                end
            end
            ST_IW: begin
                cmd.cap_s  = 1'b1;
                state_next = ST_SB_RD;
            end
            ST_SB_RD: begin
                if (stat.j_at_i) begin
                    cmd.load_inner = 1'b1;
                    state_next     = ST_CNT_K;
                end else begin
                    cmd.rd_sel = 1'b1;
                    state_next = ST_SB_CMP;
                end
            end
            ST_SB_CMP: begin
                if (stat.src_match) begin
                    cmd.next_first = 1'b1;
                    state_next     = ST_OUTER;
                end else begin
                    cmd.next_inner = 1'b1;
                    cmd.rd_sel     = 1'b1;
                    state_next     = ST_SB_RD;
                end
            end
            ST_CNT_K: begin
                if (stat.k_done) begin
                    if (stat.over_limit) begin
                        cmd.flag_src = 1'b1;
                    end
                    cmd.next_first = 1'b1;
                    state_next     = ST_OUTER;
                end else begin
                    state_next = ST_CNT_KW;
                end
            end
            ST_CNT_KW: begin
                cmd.cap_kd = 1'b1;
                if (!stat.src_match) begin
                    cmd.next_inner = 1'b1;
                    state_next     = ST_CNT_K;
                end else begin
                    state_next = ST_CNT_J;
                end
            end
            ST_CNT_J: begin
                if (stat.j_at_k) begin
                    cmd.add_count  = 1'b1;
                    cmd.next_inner = 1'b1;
                    state_next     = ST_CNT_K;
                end else begin
                    cmd.rd_sel = 1'b1;
                    state_next = ST_CNT_JW;
                end
            end
            ST_CNT_JW: begin
                if (stat.pair_match) begin
                    cmd.next_inner = 1'b1;
                    state_next     = ST_CNT_K;
                end else begin
                    cmd.next_inner = 1'b1;
                    cmd.rd_sel     = 1'b1;
                    state_next     = ST_CNT_J;
                end
            end
            ST_DONE: begin
                m_valid_next = 1'b1;
                state_next   = ST_OUT;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, busy, !s_ready)
    `ASSERT_NEXT(a_done_valid, aclk, aresetn, state_reg == ST_DONE, m_valid_reg)
    `ASSERT_IMPL(a_flag_ok, aclk, aresetn, cmd.flag_src, !stat.full_flags)
endmodule

/* rtl/core/fanout_scan_detector.sv */
// Top level of the fan-out scan detector.
// A record word (op 0) stores one source/destination pair in a WINDOW_DEPTH-entry window,
// one per clock while s_tready is high. A scan word (op 1) walks the window oldest to newest
// through the single read port of the window RAM and then presents the result.
// No words are taken during a scan. The limit register is written with cfg_we/cfg_wdata.
module fanout_scan_detector #(
    parameter int unsigned WINDOW_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // op, src_ip, dest_ip, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // flagged_count, first_flagged_ip, second_flagged_ip, pad
);
    logic [fsd_pkg::LimitWidth-1:0] limit_reg;
    fsd_pkg::fsd_cmd_t  cmd;
    fsd_pkg::fsd_stat_t stat;
    logic [1:0]  fcnt;
    logic [31:0] f0, f1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 8'd8;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    fsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_op    (s_tdata[0]),
        .s_ready (s_tready),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .cmd     (cmd),
        .stat    (stat)
    );

    fsd_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .in_src        (s_tdata[32:1]),
        .in_dest       (s_tdata[64:33]),
        .limit         (limit_reg),
        .flagged_count (fcnt),
        .first_ip      (f0),
        .second_ip     (f1)
    );

    assign m_tdata = {6'd0, f1, f0, fcnt};
endmodule
